FILE: rtl/u8dec_pkg.sv
package u8dec_pkg;

    // Width of the decoded code point and of the per-string count.
    localparam int unsigned CpWidth    = 21;
    localparam int unsigned CountWidth = 32;

    // Result kinds carried on the output channel.
    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    // One result word as held in the output queue.
    typedef struct packed {
        kind_t                 kind;
        logic [CpWidth-1:0]    code_point;
        logic [CountWidth-1:0] point_count;
        logic                  string_valid;
        logic                  last_of_run;
    } result_t;

endpackage

FILE: rtl/utf8_codepoint_decoder.sv
// UTF-8 code point decoder.
// The input channel (in_valid, in_stall, in_byte) takes one byte of a
// zero-terminated UTF-8 string per word. The output channel (out_valid,
// out_stall and the result fields) gives decoded code points, invalid
// sequence marks and one end-of-string word per zero byte that carries the
// code point count and whether the string was valid.
// An accepted byte lands in an input register; it is then decoded and, once
// the two-entry output queue has room, its results are written to that queue.
// The block takes one byte per cycle while in_stall is low. A byte that
// breaks a pending sequence can give two results and may hold the input
// while the queue drains; last_of_run marks the final result of each byte.
// When the receiver stalls, the queue fills and the input register holds its
// byte, and in_stall rises until room frees up.
// Reset clears the decoder state, the count, the error flag and the queue.
module utf8_codepoint_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          in_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          kind,
    output logic [u8dec_pkg::CpWidth-1:0]       code_point,
    output logic [u8dec_pkg::CountWidth-1:0]    point_count,
    output logic                                string_valid,
    output logic                                last_of_run
);
    import u8dec_pkg::*;

    // Input register.
    logic        in_full_reg;
    logic        in_full_next;
    logic [7:0]  byte_reg;
    logic        in_accept;

    // Decoder state.
    logic [1:0]            pending_reg;
    logic [1:0]            pending_next;
    logic [CpWidth-1:0]    partial_reg;
    logic [CpWidth-1:0]    partial_next;
    logic [CountWidth-1:0] seen_reg;
    logic [CountWidth-1:0] seen_next;
    logic                  error_reg;
    logic                  error_next;

    // Output queue: head is presented, tail waits behind it.
    result_t     head_reg;
    result_t     head_next;
    result_t     tail_reg;
    result_t     tail_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // Decode results of the byte in the input register.
    result_t     res0;
    result_t     res1;
    logic [1:0]  num_res;
    logic        broken;
    logic        fire;
    logic        pop;
    logic [1:0]  remain;
    logic [2:0]  total;

    // Lead byte path.
    logic                  lead_has;
    result_t               lead_res;
    logic                  lead_err;
    logic [CountWidth-1:0] seen_inc;

    assign pop    = out_valid && !out_stall;
    assign remain = count_reg - {1'b0, pop};
    assign total  = {1'b0, remain} + {1'b0, num_res};
    assign fire   = in_full_reg && (total <= 3'd2);

    assign in_stall  = in_full_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    assign seen_inc = (seen_reg != '1) ? seen_reg + 1'b1 : seen_reg;

    // Decode one byte: continuation, broken sequence or lead byte.
    always_comb
    begin
        lead_res     = '0;
        lead_has     = 1'b0;
        res0         = '0;
        res1         = '0;
        num_res      = 2'd0;
        broken       = 1'b0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        seen_next    = seen_reg;
        error_next   = error_reg;

        broken   = (pending_reg != 2'd0) && (byte_reg[7:6] != 2'b10);
        lead_err = error_reg || broken;

        if ((pending_reg != 2'd0) && !broken)
        begin
            // Fold a continuation byte into the partial code point.
            partial_next = {partial_reg[CpWidth-7:0], byte_reg[5:0]};
            pending_next = pending_reg - 2'd1;
            if (pending_reg == 2'd1)
            begin
                res0.kind        = KIND_POINT;
                res0.code_point  = {partial_reg[CpWidth-7:0], byte_reg[5:0]};
                res0.last_of_run = 1'b1;
                num_res          = 2'd1;
                seen_next        = seen_inc;
                partial_next     = '0;
            end
        end
        else
        begin
            if (broken)
            begin
                pending_next = 2'd0;
                partial_next = '0;
                error_next   = 1'b1;
            end

            // Lead byte handling.
            priority if (byte_reg == 8'h00)
            begin
                lead_has              = 1'b1;
                lead_res.kind         = KIND_END;
                lead_res.point_count  = lead_err ? '0 : seen_reg;
                lead_res.string_valid = !lead_err;
                seen_next             = '0;
                error_next            = 1'b0;
            end
            else if (byte_reg[7] == 1'b0)
            begin
                lead_has            = 1'b1;
                lead_res.kind       = KIND_POINT;
                lead_res.code_point = {{(CpWidth-8){1'b0}}, byte_reg};
                seen_next           = seen_inc;
            end
            else if ((byte_reg & 8'hE0) == 8'hC0)
            begin
                pending_next = 2'd1;
                partial_next = {{(CpWidth-8){1'b0}}, byte_reg & 8'h1F};
            end
            else if ((byte_reg & 8'hF0) == 8'hE0)
            begin
                pending_next = 2'd2;
                partial_next = {{(CpWidth-8){1'b0}}, byte_reg & 8'h0F};
            end
            else if ((byte_reg & 8'hF8) == 8'hF0)
            begin
                pending_next = 2'd3;
                partial_next = {{(CpWidth-8){1'b0}}, byte_reg & 8'h07};
            end
            else
            begin
                lead_has      = 1'b1;
                lead_res.kind = KIND_INVALID;
                error_next    = 1'b1;
            end
            lead_res.last_of_run = 1'b1;

            // Order the results: the broken-sequence mark comes first.
            if (broken)
            begin
                res0.kind        = KIND_INVALID;
                res0.last_of_run = !lead_has;
                res1             = lead_res;
                num_res          = lead_has ? 2'd2 : 2'd1;
            end
            else
            begin
                res0    = lead_res;
                num_res = lead_has ? 2'd1 : 2'd0;
            end
        end
    end

    // Output queue update: drop the popped word, then append new results.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = remain;
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (fire)
        begin
            count_next = total[1:0];
            unique case (remain)
                2'd0:
                begin
                    head_next = res0;
                    tail_next = res1;
                end
                2'd1:
                begin
                    tail_next = res0;
                end
                default:
                begin
                    tail_next = tail_reg;
                end
            endcase
        end
    end

    assign in_full_next = in_accept ? 1'b1 : (fire ? 1'b0 : in_full_reg);

    // Control and decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            count_reg   <= 2'd0;
            pending_reg <= 2'd0;
            partial_reg <= '0;
            seen_reg    <= '0;
            error_reg   <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            count_reg   <= count_next;
            if (fire)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                seen_reg    <= seen_next;
                error_reg   <= error_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= in_byte;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign out_valid    = (count_reg != 2'd0);
    assign kind         = head_reg.kind;
    assign code_point   = head_reg.code_point;
    assign point_count  = head_reg.point_count;
    assign string_valid = head_reg.string_valid;
    assign last_of_run  = head_reg.last_of_run;

    // The queue never holds more than two words.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("output queue overflow");

    // A non-final word of a byte always has its partner queued behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (count_reg == 2'd2))
        else $error("non-final result without its follower");

    // A decoded zero byte clears the count and error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && byte_reg == 8'h00) |=> (seen_reg == '0 && !error_reg))
        else $error("end of string did not clear the count");

    // A broken sequence always leaves an invalid mark as its first result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && broken) |-> (res0.kind == KIND_INVALID && num_res != 2'd0))
        else $error("broken sequence without invalid result");

endmodule

FILE: bench/utf8_codepoint_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_codepoint_decoder_tb;

    import u8dec_pkg::*;

    localparam int unsigned ByteTarget  = 1250;
    localparam int unsigned MaxIdle     = 12;
    localparam int unsigned LongHold    = 160;
    localparam int unsigned TailCycles  = 20;
    localparam int unsigned StuckLimit  = 2000;
    localparam int unsigned ReportLimit = 10;

    // Tracks the decoder state and holds the result words that each byte should produce.
    class utf8_scoreboard;
        bit [1:0]    conts_left;
        bit [20:0]   partial_cp;
        bit [31:0]   string_points;
        bit          string_bad;
        result_t     expected_q[$];
        int unsigned errors;

        function void push_result(kind_t k, bit [20:0] cp, bit [31:0] cnt, bit ok);
            result_t r;
            r.kind         = k;
            r.code_point   = cp;
            r.point_count  = cnt;
            r.string_valid = ok;
            r.last_of_run  = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void bump_count();
            if (string_points != 32'hFFFF_FFFF)
                string_points++;
        endfunction

        // A byte seen where a new sequence may start.
        function void decode_lead(bit [7:0] b);
            if (b == 8'h00)
            begin
                if (string_bad)
                    push_result(KIND_END, '0, '0, 1'b0);
                else
                    push_result(KIND_END, '0, string_points, 1'b1);
                string_points = '0;
                string_bad    = 1'b0;
            end
            else if (b[7] == 1'b0)
            begin
                push_result(KIND_POINT, 21'(b), '0, 1'b0);
                bump_count();
            end
            else if (b[7:5] == 3'b110)
            begin
                conts_left = 2'd1;
                partial_cp = 21'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                conts_left = 2'd2;
                partial_cp = 21'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110)
            begin
                conts_left = 2'd3;
                partial_cp = 21'(b[2:0]);
            end
            else
            begin
                push_result(KIND_INVALID, '0, '0, 1'b0);
                string_bad = 1'b1;
            end
        endfunction

        // Called for every accepted input word.
        function void note_byte(bit [7:0] b);
            int unsigned n_prior;
            result_t     r;
            n_prior = expected_q.size();
            if (conts_left != 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    partial_cp = {partial_cp[14:0], b[5:0]};
                    conts_left--;
                    if (conts_left == 0)
                    begin
                        push_result(KIND_POINT, partial_cp, '0, 1'b0);
                        bump_count();
                        partial_cp = '0;
                    end
                end
                else
                begin
                    // The sequence is broken; the byte is then taken as a new lead.
                    push_result(KIND_INVALID, '0, '0, 1'b0);
                    string_bad = 1'b1;
                    conts_left = '0;
                    partial_cp = '0;
                    decode_lead(b);
                end
            end
            else
            begin
                decode_lead(b);
            end
            if (expected_q.size() > n_prior)
            begin
                r = expected_q.pop_back();
                r.last_of_run = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        // Called for every accepted output word.
        function void check_word(logic [1:0] k, logic [20:0] cp, logic [31:0] cnt,
                                 logic ok, logic last);
            result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= ReportLimit)
                    $display("%0t: unexpected result kind=%0d cp=%h count=%0d valid=%b last=%b",
                             $time, k, cp, cnt, ok, last);
                return;
            end
            e = expected_q.pop_front();
            if (k !== e.kind || cp !== e.code_point || cnt !== e.point_count ||
                ok !== e.string_valid || last !== e.last_of_run)
            begin
                errors++;
                if (errors <= ReportLimit)
                    $display("%0t: mismatch expected kind=%0d cp=%h count=%0d valid=%b last=%b, %s",
                             $time, e.kind, e.code_point, e.point_count, e.string_valid,
                             e.last_of_run,
                             $sformatf("got kind=%0d cp=%h count=%0d valid=%b last=%b",
                                       k, cp, cnt, ok, last));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte      = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  kind;
    logic [20:0] code_point;
    logic [31:0] point_count;
    logic        string_valid;
    logic        last_of_run;

    utf8_scoreboard sb = new;
    logic [7:0]     stream_q[$];
    int unsigned    bytes_sent    = 0;
    int unsigned    stuck_cycles  = 0;
    bit             sender_calm   = 1'b0;
    bit             receiver_calm = 1'b0;
    bit             long_hold_req = 1'b0;

    utf8_codepoint_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .code_point   (code_point),
        .point_count  (point_count),
        .string_valid (string_valid),
        .last_of_run  (last_of_run)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Ends the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= StuckLimit)
            begin
                $display("FAIL utf8_codepoint_decoder");
                $finish;
            end
        end
    end

    // Offers one byte after a random gap and waits until it is taken.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, MaxIdle);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(value);
        bytes_sent++;
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
    endtask

    task automatic wait_for_drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Holds the output for a while, then takes one result word.
    task automatic take_word(input int unsigned hold);
        @(negedge clk);
        if (hold != 0)
        begin
            out_stall <= 1'b1;
            repeat (hold) @(negedge clk);
        end
        out_stall <= 1'b0;
        do
            @(posedge clk);
        while (!out_valid);
        sb.check_word(kind, code_point, point_count, string_valid, last_of_run);
    endtask

    // Appends one code point of the given length; a cut one misses continuation bytes.
    function automatic void add_point(int unsigned len, bit cut);
        logic [7:0]  lead;
        int unsigned conts;
        case (len)
            1:       lead = 8'($urandom_range(1, 127));
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        conts = len - 1;
        if (cut && conts != 0)
            conts = $urandom_range(0, conts - 1);
        stream_q.push_back(lead);
        repeat (conts) stream_q.push_back({2'b10, 6'($urandom)});
    endfunction

    // Mostly well-formed strings, with some noise, stray and cut sequences.
    function automatic void build_string();
        int unsigned n_points;
        int unsigned pick;
        n_points = $urandom_range(0, 7);
        repeat (n_points)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                stream_q.push_back(8'($urandom));
            else if (pick < 12)
                stream_q.push_back({2'b10, 6'($urandom)});
            else if (pick < 20)
                add_point($urandom_range(2, 4), 1'b1);
            else
                add_point($urandom_range(1, 4), 1'b0);
        end
        stream_q.push_back(8'h00);
    endfunction

    // Output side: random stalls per word, and one long hold-off on request.
    initial
    begin
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LongHold;
            end
            else
            begin
                hold = receiver_calm ? 0 : $urandom_range(0, MaxIdle);
            end
            take_word(hold);
        end
    end

    // Input side: directed strings first, then random strings.
    initial
    begin
        bit [1:0] mode;
        bit       held;
        bit       drained;
        held    = 1'b0;
        drained = 1'b0;
        wait (rst_n === 1'b1);

        // Empty string, ASCII extremes, 2/3/4-byte points with the 21-bit maximum,
        // bad leads, a sequence broken by ASCII, a string ended mid-sequence.
        stream_q = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00,
                     8'h80, 8'hF8, 8'hFF, 8'hC3, 8'h41, 8'h00,
                     8'hDF, 8'hE0, 8'h80, 8'h80, 8'hE1, 8'h00, 8'h01};
        send_stream();

        while (bytes_sent < ByteTarget)
        begin
            mode          = 2'((bytes_sent / 150) % 4);
            sender_calm   = mode[0];
            receiver_calm = mode[1];
            // Let the block fill up behind a stalled receiver.
            if (!held && bytes_sent >= 500)
            begin
                held          = 1'b1;
                sender_calm   = 1'b1;
                long_hold_req = 1'b1;
            end
            // Pause the input until every pending result has come out.
            if (!drained && bytes_sent >= 850)
            begin
                drained = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                wait_for_drain();
            end
            build_string();
            send_stream();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_drain();
        repeat (TailCycles) @(posedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS utf8_codepoint_decoder");
        else
            $display("FAIL utf8_codepoint_decoder");
        $finish;
    end

endmodule
